>>> sv/qpyu_pkg.sv
// ============================================================================
// qpyu_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table for the
// quaternion pitch and yaw converter.
// ============================================================================
package qpyu_pkg;

   // Input item: one orientation quaternion, signed Q1.14 components.
   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } qpyu_req_type;

   // Result item: pitch in signed Q1.13 and yaw in signed Q2.13 radians, continuous yaw in Q18.13.
   typedef struct packed {
      logic signed [14:0] pitch_angle;
      logic               pitch_clamped;
      logic signed [15:0] yaw_angle;
      logic signed [31:0] unwrapped_yaw;
   } qpyu_rsp_type;

   // Control of one CORDIC unit from the sequencer.
   typedef struct packed {
      logic       load;
      logic       step;
      logic [4:0] index;
   } qpyu_cordic_ctl_type;

   // Widths of the internal datapath.
   localparam int unsigned SUM_W = 35;   // s, sin and cos terms, scale 2^28
   localparam int unsigned ANG_W = 36;   // CORDIC angle, Q2.30 radians
   localparam int unsigned VEC_W = 40;   // CORDIC vector components
   localparam int unsigned RAD_W = 57;   // square root radicand
   localparam int unsigned ROOT_W = 29;  // square root result

   localparam logic signed [ANG_W-1:0] ANG_PI_Q30 = 36'sd3373259426;
   localparam logic signed [SUM_W-1:0] ONE_Q28 = 35'sd268435456;
   localparam logic signed [14:0] PITCH_MAX = 15'sd12868;
   localparam logic signed [15:0] YAW_MAX = 16'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic [14:0] THRESH_RESET = 15'd24576;

   // Arctangent of 2^-i in Q2.30 radians.
   function automatic logic [29:0] atan_lut(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0: val = 30'd843314857;
         5'd1: val = 30'd497837829;
         5'd2: val = 30'd263043837;
         5'd3: val = 30'd133525159;
         5'd4: val = 30'd67021687;
         5'd5: val = 30'd33543516;
         5'd6: val = 30'd16775851;
         5'd7: val = 30'd8388437;
         5'd8: val = 30'd4194283;
         5'd9: val = 30'd2097149;
         5'd10: val = 30'd1048576;
         5'd11: val = 30'd524288;
         5'd12: val = 30'd262144;
         5'd13: val = 30'd131072;
         5'd14: val = 30'd65536;
         5'd15: val = 30'd32768;
         5'd16: val = 30'd16384;
         5'd17: val = 30'd8192;
         5'd18: val = 30'd4096;
         5'd19: val = 30'd2048;
         5'd20: val = 30'd1024;
         5'd21: val = 30'd512;
         5'd22: val = 30'd256;
         5'd23: val = 30'd128;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/qpyu_serial_mult.sv
// ============================================================================
// qpyu_serial_mult
// Unsigned shift-add multiplier that retires one multiplier bit per cycle while step is high.
// ============================================================================
module qpyu_serial_mult
   import qpyu_pkg::*;
#(
   parameter int unsigned W = 16
) (
   input  logic           clock,
   input  logic           load,
   input  logic           step,
   input  logic [W-1:0]   mult_a,
   input  logic [W-1:0]   mult_b,
   output logic [2*W-1:0] product
);

   logic [W-1:0]   a_ff;
   logic [W-1:0]   a_in;
   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] prod_in;
   logic [W:0]     partial;

   // Add the multiplicand into the upper half when the low bit is set, then
   // shift the whole product register right by one.
   always_comb begin
      partial = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      a_in = a_ff;
      prod_in = prod_ff;
      if (load) begin
         a_in = mult_a;
         prod_in = {{W{1'b0}}, mult_b};
      end else if (step) begin
         prod_in = {partial, prod_ff[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

>>> sv/qpyu_isqrt.sv
// ============================================================================
// qpyu_isqrt
// Integer square root, rounded down, producing one root bit per cycle while step is high.
// ============================================================================
module qpyu_isqrt
   import qpyu_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic              step,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W:0]   trial;
   logic             fits;

   // Test one base-4 digit of the remainder per cycle while step is high; the trial
   // bit walks down two places on each step from the top of the radicand.
   always_comb begin
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
      fits = {1'b0, rem_ff} >= trial;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (load) begin
         rem_in = radicand;
         res_in = '0;
         bit_in = {1'b1, {(RAD_W-1){1'b0}}};
      end else if (step) begin
         bit_in = bit_ff >> 2;
         if (fits) begin
            rem_in = rem_ff - trial[RAD_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[ROOT_W-1:0];

endmodule

>>> sv/qpyu_cordic.sv
// ============================================================================
// qpyu_cordic
// Vectoring CORDIC that rotates (x, y) onto the x axis one micro-rotation per
// cycle while ctl.step is high and accumulates atan2(y, x) in Q2.30 radians.
// ============================================================================
module qpyu_cordic
   import qpyu_pkg::*;
(
   input  logic                    clock,
   input  qpyu_cordic_ctl_type     ctl,
   input  logic signed [SUM_W-1:0] vec_y,
   input  logic signed [SUM_W-1:0] vec_x,
   output logic signed [ANG_W-1:0] angle
);

   logic signed [VEC_W-1:0] x_ff, x_in;
   logic signed [VEC_W-1:0] y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic                    zero_ff, zero_in;
   logic signed [VEC_W-1:0] x_ext, y_ext;
   logic signed [VEC_W-1:0] x_sh, y_sh;
   logic signed [ANG_W-1:0] step_ang;

   always_comb begin
      x_ext = VEC_W'(vec_x);
      y_ext = VEC_W'(vec_y);
      x_sh = x_ff >>> ctl.index;
      y_sh = y_ff >>> ctl.index;
      step_ang = ANG_W'(signed'({1'b0, atan_lut(ctl.index)}));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         // Fold the left half plane over by a rotation of pi.
         zero_in = (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            x_in = -x_ext;
            y_in = -y_ext;
            z_in = (vec_y >= 0) ? ANG_PI_Q30 : -ANG_PI_Q30;
         end else begin
            x_in = x_ext;
            y_in = y_ext;
            z_in = '0;
         end
      end else if (ctl.step) begin
         // Rotate toward y = 0 and track the angle turned.
         if (y_ff >= 0) begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - step_ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      zero_ff <= zero_in;
   end

   assign angle = zero_ff ? '0 : z_ff;

endmodule

>>> sv/quaternion_pitch_yaw_unwrap.sv
// ============================================================================
// quaternion_pitch_yaw_unwrap
// Converts an orientation quaternion into pitch and yaw and keeps a
// continuous, saturating yaw that is unwrapped across the +-pi boundary.
// ============================================================================
// Usage:
// An item is accepted on req_data when req_valid is high and req_stall low.
// The block works on one item at a time and holds req_stall high while busy.
// Each item runs through bit-serial multipliers, a bit-serial square of the
// pitch term, a square root that yields one bit per cycle and two CORDIC
// units in parallel, one micro-rotation per cycle, plus states for loading,
// rounding and accumulating.
// The result sits in an output register; while rsp_stall holds it, the next
// item is still accepted and computed, and it waits at the end until the
// output register is free. csr_wr_en writes the unwrap threshold.
// Synchronous reset clears the sequencer, the output valid, the previous yaw
// and the accumulator, and sets the threshold to 24576.
// ============================================================================
module quaternion_pitch_yaw_unwrap
   import qpyu_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  qpyu_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output qpyu_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [14:0]  csr_wr_data
);

   localparam logic [4:0] MULQ_LAST = 5'd15;
   localparam logic [4:0] MULS_LAST = 5'd27;
   localparam logic [4:0] SQRT_LAST = 5'd28;
   localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_MULQ    = 11'b000_0000_0010,
      ST_SUMS    = 11'b000_0000_0100,
      ST_SQLD    = 11'b000_0000_1000,
      ST_MULS    = 11'b000_0001_0000,
      ST_SQRT_LD = 11'b000_0010_0000,
      ST_SQRT    = 11'b000_0100_0000,
      ST_CORD_LD = 11'b000_1000_0000,
      ST_CORD    = 11'b001_0000_0000,
      ST_ROUND   = 11'b010_0000_0000,
      ST_ACCUM   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [3:0]  neg_ff, neg_in;
   logic [15:0] mag_x, mag_y, mag_z, mag_w;
   logic [31:0] prod_wy, prod_zx, prod_wz, prod_xy, prod_yy, prod_zz;
   logic signed [32:0] sp_wy, sp_zx, sp_wz, sp_xy;

   logic signed [SUM_W-1:0] s_ff, s_in;
   logic signed [SUM_W-1:0] sy_ff, sy_in;
   logic signed [SUM_W-1:0] cy_ff, cy_in;
   logic                    clamp_ff, clamp_in;
   logic signed [SUM_W-1:0] s_abs;
   logic [55:0]             s_sq;
   logic [RAD_W-1:0]        radicand;
   logic [ROOT_W-1:0]       root;

   qpyu_cordic_ctl_type     ctl_pitch, ctl_yaw;
   logic signed [ANG_W-1:0] ang_pitch, ang_yaw;
   logic signed [18:0]      rnd_pitch, rnd_yaw;

   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic signed [17:0] dyaw_ff, dyaw_in;
   logic signed [17:0] thr_s, d1, d2;
   logic signed [33:0] acc_sum;
   logic signed [31:0] acc_sat;

   logic [14:0]        thr_ff, thr_in;
   logic signed [15:0] prev_yaw_ff, prev_yaw_in;
   logic signed [31:0] acc_ff, acc_in;

   logic         rsp_valid_ff, rsp_valid_in;
   qpyu_rsp_type rsp_data_ff, rsp_data_in;
   logic         out_free;
   logic         mulq_load, muls_load;

   // Magnitudes of the incoming components for the unsigned multipliers.
   always_comb begin
      mag_x = req_data.quat_x[15] ? 16'(-req_data.quat_x) : 16'(req_data.quat_x);
      mag_y = req_data.quat_y[15] ? 16'(-req_data.quat_y) : 16'(req_data.quat_y);
      mag_z = req_data.quat_z[15] ? 16'(-req_data.quat_z) : 16'(req_data.quat_z);
      mag_w = req_data.quat_w[15] ? 16'(-req_data.quat_w) : 16'(req_data.quat_w);
   end

   assign mulq_load = (state_ff == ST_IDLE) && req_valid;
   assign muls_load = (state_ff == ST_SQLD);

   qpyu_serial_mult #(.W(16)) u_mul_wy (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_w), .mult_b(mag_y), .product(prod_wy));
   qpyu_serial_mult #(.W(16)) u_mul_zx (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_z), .mult_b(mag_x), .product(prod_zx));
   qpyu_serial_mult #(.W(16)) u_mul_wz (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_w), .mult_b(mag_z), .product(prod_wz));
   qpyu_serial_mult #(.W(16)) u_mul_xy (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_x), .mult_b(mag_y), .product(prod_xy));
   qpyu_serial_mult #(.W(16)) u_mul_yy (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_y), .mult_b(mag_y), .product(prod_yy));
   qpyu_serial_mult #(.W(16)) u_mul_zz (
      .clock(clock), .load(mulq_load), .step(state_ff == ST_MULQ),
      .mult_a(mag_z), .mult_b(mag_z), .product(prod_zz));

   // Square of the pitch term; only the unclamped case needs it, where the
   // magnitude fits in 28 bits.
   assign s_abs = s_ff[SUM_W-1] ? -s_ff : s_ff;

   qpyu_serial_mult #(.W(28)) u_mul_ss (
      .clock(clock), .load(muls_load), .step(state_ff == ST_MULS),
      .mult_a(s_abs[27:0]), .mult_b(s_abs[27:0]), .product(s_sq));

   // Cosine of pitch scaled by 2^28 is sqrt(2^56 - s^2).
   assign radicand = {1'b1, {(RAD_W-1){1'b0}}} - {1'b0, s_sq};

   qpyu_isqrt u_isqrt (
      .clock(clock), .load(state_ff == ST_SQRT_LD), .step(state_ff == ST_SQRT),
      .radicand(radicand), .root(root));

   // Both CORDIC units rotate together; the yaw unit is loaded early.
   always_comb begin
      ctl_pitch.load = (state_ff == ST_CORD_LD);
      ctl_pitch.step = (state_ff == ST_CORD);
      ctl_pitch.index = cnt_ff;
      ctl_yaw.load = (state_ff == ST_SQLD);
      ctl_yaw.step = (state_ff == ST_CORD);
      ctl_yaw.index = cnt_ff;
   end

   qpyu_cordic u_cordic_pitch (
      .clock(clock), .ctl(ctl_pitch), .vec_y(s_ff),
      .vec_x(SUM_W'(signed'({1'b0, root}))), .angle(ang_pitch));
   qpyu_cordic u_cordic_yaw (
      .clock(clock), .ctl(ctl_yaw), .vec_y(sy_ff), .vec_x(cy_ff), .angle(ang_yaw));

   // Signed products and the three sums at scale 2^28.
   always_comb begin
      sp_wy = neg_ff[0] ? -$signed({1'b0, prod_wy}) : $signed({1'b0, prod_wy});
      sp_zx = neg_ff[1] ? -$signed({1'b0, prod_zx}) : $signed({1'b0, prod_zx});
      sp_wz = neg_ff[2] ? -$signed({1'b0, prod_wz}) : $signed({1'b0, prod_wz});
      sp_xy = neg_ff[3] ? -$signed({1'b0, prod_xy}) : $signed({1'b0, prod_xy});
      s_in = s_ff;
      sy_in = sy_ff;
      cy_in = cy_ff;
      clamp_in = clamp_ff;
      if (state_ff == ST_SUMS) begin
         s_in = (SUM_W'(sp_wy) - SUM_W'(sp_zx)) <<< 1;
         sy_in = (SUM_W'(sp_wz) + SUM_W'(sp_xy)) <<< 1;
         cy_in = ONE_Q28 - ((SUM_W'(prod_yy) + SUM_W'(prod_zz)) <<< 1);
      end
      if (state_ff == ST_SQLD) begin
         clamp_in = (s_ff >= ONE_Q28) || (s_ff <= -ONE_Q28);
      end
   end

   // Round the angles to Q2.13, half up, and clamp them.
   always_comb begin
      rnd_pitch = 19'((ang_pitch + ANG_W'(65536)) >>> 17);
      rnd_yaw = 19'((ang_yaw + ANG_W'(65536)) >>> 17);
      pitch_in = pitch_ff;
      yaw_in = yaw_ff;
      dyaw_in = dyaw_ff;
      if (state_ff == ST_ROUND) begin
         if (clamp_ff) begin
            pitch_in = s_ff[SUM_W-1] ? -PITCH_MAX : PITCH_MAX;
         end else if (rnd_pitch > 19'(PITCH_MAX)) begin
            pitch_in = PITCH_MAX;
         end else if (rnd_pitch < -19'(PITCH_MAX)) begin
            pitch_in = -PITCH_MAX;
         end else begin
            pitch_in = 15'(rnd_pitch);
         end
         if (rnd_yaw > 19'(YAW_MAX)) begin
            yaw_in = YAW_MAX;
            dyaw_in = 18'(YAW_MAX) - 18'(prev_yaw_ff);
         end else if (rnd_yaw < -19'(YAW_MAX)) begin
            yaw_in = -YAW_MAX;
            dyaw_in = -18'(YAW_MAX) - 18'(prev_yaw_ff);
         end else begin
            yaw_in = 16'(rnd_yaw);
            dyaw_in = 18'(rnd_yaw) - 18'(prev_yaw_ff);
         end
      end
   end

   // Unwrap the yaw step and add it to the saturating accumulator.
   always_comb begin
      thr_s = 18'(signed'({1'b0, thr_ff}));
      d1 = (dyaw_ff > thr_s) ? dyaw_ff - TWO_PI_Q13 : dyaw_ff;
      d2 = (d1 < -thr_s) ? d1 + TWO_PI_Q13 : d1;
      acc_sum = 34'(acc_ff) + 34'(d2);
      if (acc_sum > 34'sd2147483647) begin
         acc_sat = 32'sh7FFF_FFFF;
      end else if (acc_sum < -34'sd2147483648) begin
         acc_sat = 32'sh8000_0000;
      end else begin
         acc_sat = 32'(acc_sum);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = {req_data.quat_x[15] ^ req_data.quat_y[15],
                         req_data.quat_w[15] ^ req_data.quat_z[15],
                         req_data.quat_z[15] ^ req_data.quat_x[15],
                         req_data.quat_w[15] ^ req_data.quat_y[15]};
               cnt_in = '0;
               state_in = ST_MULQ;
            end
         end
         ST_MULQ: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MULQ_LAST) begin
               state_in = ST_SUMS;
            end
         end
         ST_SUMS: begin
            state_in = ST_SQLD;
         end
         ST_SQLD: begin
            cnt_in = '0;
            state_in = ST_MULS;
         end
         ST_MULS: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MULS_LAST) begin
               state_in = ST_SQRT_LD;
            end
         end
         ST_SQRT_LD: begin
            cnt_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_CORD_LD;
            end
         end
         ST_CORD_LD: begin
            cnt_in = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORD_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register, unwrap state and the threshold register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      prev_yaw_in = prev_yaw_ff;
      acc_in = acc_ff;
      thr_in = csr_wr_en ? csr_wr_data : thr_ff;
      if ((state_ff == ST_ACCUM) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.pitch_angle = pitch_ff;
         rsp_data_in.pitch_clamped = clamp_ff;
         rsp_data_in.yaw_angle = yaw_ff;
         rsp_data_in.unwrapped_yaw = acc_sat;
         prev_yaw_in = yaw_ff;
         acc_in = acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_yaw_ff <= '0;
         acc_ff <= '0;
         thr_ff <= THRESH_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_yaw_ff <= prev_yaw_in;
         acc_ff <= acc_in;
         thr_ff <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      s_ff <= s_in;
      sy_ff <= sy_in;
      cy_ff <= cy_in;
      clamp_ff <= clamp_in;
      pitch_ff <= pitch_in;
      yaw_ff <= yaw_in;
      dyaw_ff <= dyaw_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
